@@ design/apq_pkg.sv @@
// Shared types, constants and codes for the ascending priority queue unit.
`timescale 1ns / 1ps

package apq_pkg;

	// Number of cells in the chain and the width of the entry counter.
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths.
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 5;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Request commands.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Operations broadcast to every cell of the chain.
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// Request payload.
	typedef struct packed {
		logic command;
		logic signed [VAL_W-1:0] value;
	} apq_request_t;

	// Result payload.
	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [STATUS_W-1:0] status;
		logic [COUNT_OUT_W-1:0] count_after;
	} apq_result_t;

	// Control broadcast from the top level to the cells.
	typedef struct packed {
		logic [1:0] op;
		logic signed [VAL_W-1:0] value;
	} apq_cell_ctl_t;

endpackage

@@ design/ascending_priority_queue_unit.sv @@
// Top level of the ascending priority queue: request stage, entry counter and cell chain.
//
// Channel    Direction  Handshake                    Payload
// request    in         start high while busy low    request (command, value)
// result     out        done high for one cycle      result (result_value, status, count_after)
// capacity   in         capacity_we high             capacity_data
//
// A request is first taken into the request stage; from there the cell chain and the
// result register update together, and a new request is taken only once the stage is free.
// busy is high for the one cycle in which the chain is working.
// The chain keeps the entries sorted, so the smallest is always in the first cell.
// Reset clears the entry count and restores the capacity to sixteen; the cells need none.
// The receiver cannot stall: done is high for one cycle only.
`timescale 1ns / 1ps

module ascending_priority_queue_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input apq_pkg::apq_request_t request,
	output logic done,
	output apq_pkg::apq_result_t result,
	input logic capacity_we,
	input logic [apq_pkg::CAP_W-1:0] capacity_data
);
	import apq_pkg::*;

	logic pend_s1;
	apq_request_t req_s1;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic done_q;
	apq_result_t result_q;

	logic [CNT_W-1:0] limit;
	logic full;
	logic empty;
	logic [DEPTH-1:0] occ;
	apq_cell_ctl_t ctl;
	logic signed [VAL_W-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0] cell_before;

	assign busy = pend_s1;
	assign done = done_q;
	assign result = result_q;

	// Request stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= start && !pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !pend_s1) begin
			req_s1 <= request;
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity_data;
		end
	end

	// The effective capacity saturates at the length of the chain.
	always_comb begin
		if (int'(capacity_q) > DEPTH) begin
			limit = CNT_W'(DEPTH);
		end else begin
			limit = CNT_W'(capacity_q);
		end
	end

	assign full = (count_q >= limit);
	assign empty = (count_q == '0);

	// Occupancy of each cell follows from the entry count.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (count_q > CNT_W'(i));
		end
	end

	// Operation for the chain in the working cycle.
	always_comb begin
		ctl.value = req_s1.value;
		ctl.op = OP_HOLD;
		if (pend_s1) begin
			if (req_s1.command == CMD_INSERT && !full) begin
				ctl.op = OP_INSERT;
			end else if (req_s1.command == CMD_DELETE && !empty) begin
				ctl.op = OP_DELETE;
			end
		end
	end

	// The cell chain.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VAL_W-1:0] lv;
		logic lb;
		logic signed [VAL_W-1:0] rv;

		if (g == 0) begin : g_first
			assign lv = '0;
			assign lb = 1'b0;
		end else begin : g_inner
			assign lv = cell_value[g-1];
			assign lb = cell_before[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign rv = '0;
		end else begin : g_body
			assign rv = cell_value[g+1];
		end

		apq_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.occ(occ[g]),
			.left_value(lv),
			.left_before(lb),
			.right_value(rv),
			.value(cell_value[g]),
			.ahead(cell_before[g])
		);
	end

	// Entry counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (ctl.op)
				OP_INSERT: count_q <= count_q + CNT_W'(1);
				OP_DELETE: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pend_s1;
		end
	end

	// Result payload, formed from the state before the chain updates.
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			unique case (ctl.op)
				OP_INSERT: begin
					result_q.result_value <= '0;
					result_q.status <= ST_OK;
					result_q.count_after <= COUNT_OUT_W'(count_q + CNT_W'(1));
				end
				OP_DELETE: begin
					result_q.result_value <= cell_value[0];
					result_q.status <= ST_OK;
					result_q.count_after <= COUNT_OUT_W'(count_q - CNT_W'(1));
				end
				default: begin
					if (req_s1.command == CMD_INSERT) begin
						result_q.result_value <= '0;
						result_q.status <= ST_FULL;
					end else begin
						result_q.result_value <= '1;
						result_q.status <= ST_EMPTY;
					end
					result_q.count_after <= COUNT_OUT_W'(count_q);
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held for more than one cycle");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request did not set busy");

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result strobe without a request in flight");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH) else $error("entry count beyond chain length");

	a_empty_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |-> (result.count_after == '0))
		else $error("empty status with non-zero count");
`endif

endmodule

@@ design/apq_cell.sv @@
// One cell of the sorted chain: holds one entry and exchanges it with its neighbours.
`timescale 1ns / 1ps

module apq_cell (
	input logic clk,
	input apq_pkg::apq_cell_ctl_t ctl,
	input logic occ,
	input logic signed [apq_pkg::VAL_W-1:0] left_value,
	input logic left_before,
	input logic signed [apq_pkg::VAL_W-1:0] right_value,
	output logic signed [apq_pkg::VAL_W-1:0] value,
	output logic ahead
);
	import apq_pkg::*;

	logic signed [VAL_W-1:0] value_q;

	// The new value belongs in front of this entry when the cell is free or the
	// stored entry is strictly larger, so equal values keep their arrival order.
	assign ahead = !occ || ($signed(ctl.value) < $signed(value_q));
	assign value = value_q;

	// An insert shifts the larger entries one place right; a delete shifts all left.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_INSERT: begin
				if (ahead) begin
					value_q <= left_before ? left_value : ctl.value;
				end
			end
			OP_DELETE: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule
